// ===== src/bps_pkg.sv =====
// shared constants, codes and types for the bucketed priority stack
package bps_pkg;

   localparam int CAPACITY = 256;
   localparam int LEVELS   = 16;
   localparam int ELEM_W   = 32;
   localparam int SLOT_W   = $clog2(CAPACITY);
   localparam int LEVEL_W  = $clog2(LEVELS);
   localparam int COUNT_W  = $clog2(CAPACITY + 1);

   localparam logic [1:0] ACT_PUSH = 2'd0;
   localparam logic [1:0] ACT_POP  = 2'd1;
   localparam logic [1:0] ACT_PEEK = 2'd2;

   localparam logic [1:0] STAT_OK    = 2'd0;
   localparam logic [1:0] STAT_FULL  = 2'd1;
   localparam logic [1:0] STAT_EMPTY = 2'd2;
   localparam logic [1:0] STAT_LEVEL = 2'd3;

   typedef struct packed {
      logic [1:0]         action;
      logic [ELEM_W-1:0]  value;
      logic [LEVEL_W-1:0] level;
   } req_type;

   typedef struct packed {
      logic [ELEM_W-1:0]  popped_value;
      logic [ELEM_W-1:0]  top_value;
      logic [LEVEL_W-1:0] top_level;
      logic [COUNT_W-1:0] count;
      logic               is_empty;
      logic [1:0]         status;
   } rsp_type;

   typedef struct packed {
      logic              rd_en;
      logic [SLOT_W-1:0] rd_addr;
      logic              elem_we;
      logic              link_we;
      logic [SLOT_W-1:0] wr_addr;
      logic [ELEM_W-1:0] elem_wdata;
      logic [SLOT_W-1:0] link_wdata;
   } store_ctl_type;

endpackage

// ===== src/bps_store.sv =====
// element and link memories with one shared read port and write forwarding
module bps_store (
   input  logic                  clock,
   input  bps_pkg::store_ctl_type ctl,
   output logic [bps_pkg::ELEM_W-1:0] elem_rdata,
   output logic [bps_pkg::SLOT_W-1:0] link_rdata
);
   import bps_pkg::*;

   logic [ELEM_W-1:0] elem_mem [CAPACITY];
   logic [SLOT_W-1:0] link_mem [CAPACITY];

   logic [ELEM_W-1:0] elem_rd_ff;
   logic [SLOT_W-1:0] link_rd_ff;
   logic              elem_fwd_ff;
   logic              link_fwd_ff;
   logic [ELEM_W-1:0] elem_fwd_data_ff;
   logic [SLOT_W-1:0] link_fwd_data_ff;

   always_ff @(posedge clock) begin
      if (ctl.elem_we) begin
         elem_mem[ctl.wr_addr] <= ctl.elem_wdata;
      end
      if (ctl.link_we) begin
         link_mem[ctl.wr_addr] <= ctl.link_wdata;
      end
      if (ctl.rd_en) begin
         elem_rd_ff       <= elem_mem[ctl.rd_addr];
         link_rd_ff       <= link_mem[ctl.rd_addr];
         // a read of the entry being written returns the new data
         elem_fwd_ff      <= ctl.elem_we && (ctl.wr_addr == ctl.rd_addr);
         link_fwd_ff      <= ctl.link_we && (ctl.wr_addr == ctl.rd_addr);
         elem_fwd_data_ff <= ctl.elem_wdata;
         link_fwd_data_ff <= ctl.link_wdata;
      end
   end

   assign elem_rdata = elem_fwd_ff ? elem_fwd_data_ff : elem_rd_ff;
   assign link_rdata = link_fwd_ff ? link_fwd_data_ff : link_rd_ff;

endmodule

// ===== src/bucketed_priority_stack.sv =====
// Bucketed priority stack: one LIFO list per priority level over a shared element store.
// req channel (valid/ready): push a value at a level, pop the top entry, or peek.
// rsp channel (valid/ready): one response per request with the popped value, the
// new top value and its level, the element count, an empty flag and a status.
// csr_write_enable/csr_write_data set the highest level a push may use.
// A request is taken only while no other one is in flight; rsp_valid rises after the
// response register load, and the next request is taken only once the block is idle
// again, never before the last one is through. The three
// steps are set by the element/link store: one read of the list entry or free slot,
// one write-back together with the read of the new top element, and the response
// register load. A held response waits in the output register while the next
// request is already read and updated; only the load step stalls on rsp_ready.
// Reset empties every list, the free list and the count, and sets the highest
// level to 15; the store itself is not cleared.
module bucketed_priority_stack (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  bps_pkg::req_type              req_data,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output bps_pkg::rsp_type              rsp_data,
   input  logic                          csr_write_enable,
   input  logic [bps_pkg::LEVEL_W-1:0]   csr_write_data
);
   import bps_pkg::*;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_UPD  = 2'd1;
   localparam logic [1:0] ST_DONE = 2'd2;

   function automatic logic [LEVEL_W-1:0] find_top(input logic [LEVELS-1:0] map);
      logic [LEVEL_W-1:0] r;
      r = '0;
      for (int i = 0; i < LEVELS; i++) begin
         if (map[i]) begin
            r = LEVEL_W'(i);
         end
      end
      return r;
   endfunction

   // control state
   logic [1:0]         state_ff, state_in;
   logic [LEVELS-1:0]  map_ff, map_in;
   logic               free_valid_ff, free_valid_in;
   logic [COUNT_W-1:0] fresh_ff, fresh_in;
   logic [COUNT_W-1:0] occ_ff, occ_in;
   logic [LEVEL_W-1:0] hp_ff, hp_in;
   logic               rsp_valid_ff, rsp_valid_in;

   // payload state
   logic [SLOT_W-1:0]  head_ff [LEVELS];
   logic [SLOT_W-1:0]  free_head_ff, free_head_in;
   req_type            req_ff, req_in;
   logic [LEVEL_W-1:0] top_ff, top_in;
   logic               any_ff, any_in;
   logic [SLOT_W-1:0]  head_rd_ff, head_rd_in;
   logic [ELEM_W-1:0]  popped_ff, popped_in;
   logic [1:0]         status_ff, status_in;
   logic [LEVEL_W-1:0] newtop_ff, newtop_in;
   logic               new_any_ff, new_any_in;
   rsp_type            rsp_ff, rsp_in;

   store_ctl_type      ctl;
   logic [ELEM_W-1:0]  elem_rdata;
   logic [SLOT_W-1:0]  link_rdata;

   logic [LEVEL_W-1:0] old_top;
   logic               is_push, is_pop, bad_lvl, full, push_ok, pop_ok, pop_last;
   logic [SLOT_W-1:0]  alloc_slot, pop_slot, pop_next, newslot;
   logic [LEVELS-1:0]  map_rem;
   logic [LEVEL_W-1:0] hsel, head_raddr;
   logic [SLOT_W-1:0]  head_q;
   logic               head_we;
   logic [LEVEL_W-1:0] head_waddr;
   logic [SLOT_W-1:0]  head_wdata;
   logic               rsp_load;

   bps_store u_store (
      .clock      (clock),
      .ctl        (ctl),
      .elem_rdata (elem_rdata),
      .link_rdata (link_rdata)
   );

   assign old_top = find_top(map_ff);

   // decode of the request in flight, valid in the update step
   always_comb begin
      is_push    = (req_ff.action == ACT_PUSH);
      is_pop     = (req_ff.action == ACT_POP);
      bad_lvl    = (req_ff.level > hp_ff);
      full       = (occ_ff == COUNT_W'(CAPACITY));
      push_ok    = is_push && !bad_lvl && !full;
      pop_ok     = is_pop && any_ff;
      alloc_slot = free_valid_ff ? free_head_ff : fresh_ff[SLOT_W-1:0];
      pop_slot   = head_rd_ff;
      pop_next   = link_rdata;
      // a link to its own slot ends the list
      pop_last   = (pop_next == pop_slot);
      map_rem    = map_ff & ~(LEVELS'(1) << top_ff);
      hsel       = (pop_ok && pop_last) ? find_top(map_rem) : top_ff;
   end

   // single read port on the head table
   assign head_raddr = (state_ff == ST_IDLE)
                       ? ((req_data.action == ACT_PUSH) ? req_data.level : old_top)
                       : hsel;
   assign head_q     = head_ff[head_raddr];

   assign rsp_load = (state_ff == ST_DONE) && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      state_in      = state_ff;
      map_in        = map_ff;
      free_valid_in = free_valid_ff;
      free_head_in  = free_head_ff;
      fresh_in      = fresh_ff;
      occ_in        = occ_ff;
      req_in        = req_ff;
      top_in        = top_ff;
      any_in        = any_ff;
      head_rd_in    = head_rd_ff;
      popped_in     = popped_ff;
      status_in     = status_ff;
      newtop_in     = newtop_ff;
      new_any_in    = new_any_ff;
      newslot       = head_q;
      head_we       = 1'b0;
      head_waddr    = req_ff.level;
      head_wdata    = alloc_slot;
      ctl           = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               req_in      = req_data;
               top_in      = old_top;
               any_in      = |map_ff;
               head_rd_in  = head_q;
               ctl.rd_en   = 1'b1;
               ctl.rd_addr = (req_data.action == ACT_POP) ? head_q : free_head_ff;
               state_in    = ST_UPD;
            end
         end
         ST_UPD: begin
            popped_in = '0;
            status_in = STAT_OK;
            newtop_in = top_ff;
            if (push_ok) begin
               ctl.elem_we    = 1'b1;
               ctl.link_we    = 1'b1;
               ctl.wr_addr    = alloc_slot;
               ctl.elem_wdata = req_ff.value;
               ctl.link_wdata = map_ff[req_ff.level] ? head_rd_ff : alloc_slot;
               head_we        = 1'b1;
               head_waddr     = req_ff.level;
               head_wdata     = alloc_slot;
               map_in         = map_ff | (LEVELS'(1) << req_ff.level);
               if (free_valid_ff) begin
                  free_valid_in = (link_rdata != alloc_slot);
                  free_head_in  = link_rdata;
               end else begin
                  fresh_in = fresh_ff + COUNT_W'(1);
               end
               occ_in = occ_ff + COUNT_W'(1);
               if (!any_ff || req_ff.level >= top_ff) begin
                  newtop_in = req_ff.level;
                  newslot   = alloc_slot;
               end
            end else if (pop_ok) begin
               popped_in      = elem_rdata;
               ctl.link_we    = 1'b1;
               ctl.wr_addr    = pop_slot;
               ctl.link_wdata = free_valid_ff ? free_head_ff : pop_slot;
               free_head_in   = pop_slot;
               free_valid_in  = 1'b1;
               occ_in         = occ_ff - COUNT_W'(1);
               if (pop_last) begin
                  map_in    = map_rem;
                  newtop_in = hsel;
               end else begin
                  head_we    = 1'b1;
                  head_waddr = top_ff;
                  head_wdata = pop_next;
                  newslot    = pop_next;
               end
            end else if (is_push) begin
               status_in = bad_lvl ? STAT_LEVEL : STAT_FULL;
            end else if (is_pop) begin
               status_in = STAT_EMPTY;
            end
            new_any_in  = |map_in;
            // fetch the new top element, forwarded if just written
            ctl.rd_en   = 1'b1;
            ctl.rd_addr = newslot;
            state_in    = ST_DONE;
         end
         ST_DONE: begin
            if (rsp_load) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_in.popped_value = popped_ff;
      rsp_in.top_value    = new_any_ff ? elem_rdata : '0;
      rsp_in.top_level    = new_any_ff ? newtop_ff : '0;
      rsp_in.count        = occ_ff;
      rsp_in.is_empty     = (occ_ff == '0);
      rsp_in.status       = status_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
      hp_in = csr_write_enable ? csr_write_data : hp_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         map_ff        <= '0;
         free_valid_ff <= 1'b0;
         fresh_ff      <= '0;
         occ_ff        <= '0;
         hp_ff         <= LEVEL_W'(LEVELS - 1);
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         map_ff        <= map_in;
         free_valid_ff <= free_valid_in;
         fresh_ff      <= fresh_in;
         occ_ff        <= occ_in;
         hp_ff         <= hp_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (head_we) begin
         head_ff[head_waddr] <= head_wdata;
      end
      free_head_ff <= free_head_in;
      req_ff       <= req_in;
      top_ff       <= top_in;
      any_ff       <= any_in;
      head_rd_ff   <= head_rd_in;
      popped_ff    <= popped_in;
      status_ff    <= status_in;
      newtop_ff    <= newtop_in;
      new_any_ff   <= new_any_in;
      if (rsp_load) begin
         rsp_ff <= rsp_in;
      end
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule
